@@ design/tspk_pkg.sv @@
// Shared constants and types for the transport stream packetizer.
`timescale 1ns / 1ps

package tspk_pkg;

    localparam int PAYLOAD_LEN = 184;
    localparam int PKT_LEN     = 188;
    localparam int HDR_LEN     = PKT_LEN - PAYLOAD_LEN;
    localparam int ADDR_W      = $clog2(PAYLOAD_LEN);
    localparam int BIDX_W      = $clog2(PKT_LEN);
    localparam int PID_W       = 13;
    localparam int CC_W        = 4;

    localparam logic [7:0]       TS_SYNC_MARK = 8'h47;
    localparam logic [7:0]       STUFF_BYTE   = 8'hFF;
    localparam logic [PID_W-1:0] PID_RESET    = 13'h0040;

    // Adaptation field control codes
    localparam logic [1:0] AFC_PAYLOAD_ONLY = 2'b01;
    localparam logic [1:0] AFC_ADAPT_PAYLOAD = 2'b11;

    // Packet start request from the input side to the emitter
    typedef struct packed {
        logic              valid;
        logic              pusi;
        logic              pad;
        logic [ADDR_W-1:0] diff;
        logic [CC_W-1:0]   cc;
        logic [PID_W-1:0]  pid;
    } t_launch;

endpackage

@@ design/ts_payload_packetizer_unit.sv @@
// Top level of the transport stream packetizer: input side, counters and PID register.
//
//  channel   | dir | payload                                   | handshake
//  s_axis    | in  | tdata: payload_byte[7:0]; tuser: unit_first; tlast: unit_last | tvalid/tready
//  m_axis    | out | tdata: packet_word[31:0]; tlast: packet_end | tvalid/tready
//  cfg       | in  | i_cfg_wdata: stream_pid[12:0]             | i_cfg_we
//
// An input byte is written to the payload store on accept.
// A packet is sent as 47 words; the emitter walks its 188 bytes one per cycle,
// reading payload bytes through the store read port, so the input is held off while it is busy.
// Output back-pressure stalls the emitter and lengthens that window.
// Reset is synchronous, active low; the store itself is not cleared.
`timescale 1ns / 1ps

module ts_payload_packetizer_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] payload_byte
    input  logic                       s_axis_tuser,   // [0] unit_first
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,   // [31:0] packet_word
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_we,
    input  logic [tspk_pkg::PID_W-1:0] i_cfg_wdata
);

    logic [tspk_pkg::ADDR_W-1:0] r_fill;
    logic [tspk_pkg::CC_W-1:0]   r_cc;
    logic                        r_pending;
    logic [tspk_pkg::PID_W-1:0]  r_pid;
    logic [tspk_pkg::ADDR_W-1:0] n_fill;
    logic [tspk_pkg::CC_W-1:0]   n_cc;
    logic                        n_pending;

    logic                        accept;
    logic [tspk_pkg::ADDR_W-1:0] fill_inc;
    logic                        store_full;
    tspk_pkg::t_launch           launch;
    logic                        emit_busy;
    logic                        rd_en;
    logic [tspk_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  rd_data;

    assign s_axis_tready = !emit_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fill_inc      = r_fill + 1'b1;
    assign store_full    = fill_inc == tspk_pkg::ADDR_W'(tspk_pkg::PAYLOAD_LEN);

    always_comb begin
        launch.valid = accept && (store_full || s_axis_tlast);
        launch.pusi  = r_pending || s_axis_tuser;
        launch.pad   = !store_full;
        // Padding length in front of the payload; zero for a full packet
        launch.diff  = tspk_pkg::ADDR_W'(tspk_pkg::PAYLOAD_LEN) - fill_inc;
        launch.cc    = r_cc;
        launch.pid   = r_pid;
    end

    always_comb begin
        n_fill    = r_fill;
        n_cc      = r_cc;
        n_pending = r_pending;
        if (accept) begin
            if (launch.valid) begin
                n_fill    = '0;
                n_pending = 1'b0;
                n_cc      = r_cc + 1'b1;
            end else begin
                n_fill    = fill_inc;
                n_pending = r_pending || s_axis_tuser;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_cc      <= '0;
            r_pending <= 1'b0;
            r_pid     <= tspk_pkg::PID_RESET;
        end else begin
            r_fill    <= n_fill;
            r_cc      <= n_cc;
            r_pending <= n_pending;
            if (i_cfg_we) begin
                r_pid <= i_cfg_wdata;
            end
        end
    end

    tspk_store u_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_fill),
        .i_wdata (s_axis_tdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    tspk_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_launch  (launch),
        .o_busy    (emit_busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_word    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < tspk_pkg::ADDR_W'(tspk_pkg::PAYLOAD_LEN))
        else $error("fill count past payload length");

    a_cc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch.valid |=> r_cc == $past(r_cc) + 1'b1 && r_fill == '0)
        else $error("counters not updated after packet launch");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch.valid |=> !s_axis_tready)
        else $error("input open while packet is emitted");
`endif

endmodule

@@ design/tspk_store.sv @@
// Payload byte store: one write port, one read port with registered data.
`timescale 1ns / 1ps

module tspk_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [tspk_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                  i_wdata,
    input  logic                        i_re,
    input  logic [tspk_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                  o_rdata
);

    logic [7:0] r_mem [0:tspk_pkg::PAYLOAD_LEN-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tspk_emit.sv @@
// Packet emitter: walks the 188 packet bytes, reads payload from the store, packs words.
`timescale 1ns / 1ps

module tspk_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tspk_pkg::t_launch           i_launch,
    output logic                        o_busy,
    output logic                        o_rd_en,
    output logic [tspk_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                  i_rd_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [31:0]                 o_word,
    output logic                        o_last
);

    // byte issue stage
    logic                               r_s0_active;
    logic [tspk_pkg::BIDX_W-1:0]        r_bidx;
    logic                               r_pusi;
    logic                               r_pad;
    logic [tspk_pkg::ADDR_W-1:0]        r_diff;
    logic [tspk_pkg::CC_W-1:0]          r_cc;
    logic [tspk_pkg::PID_W-1:0]         r_pid;
    // byte collect stage
    logic                               r_s1_valid;
    logic                               r_s1_mem;
    logic [7:0]                         r_s1_const;
    logic                               r_s1_wend;
    logic                               r_s1_last;
    logic [23:0]                        r_acc;
    // output register
    logic                               r_out_valid;
    logic [31:0]                        r_out_word;
    logic                               r_out_last;
    logic                               n_out_valid;

    logic                               advance;
    logic                               is_hdr;
    logic [tspk_pkg::ADDR_W-1:0]        pos;
    logic                               from_mem;
    logic [7:0]                         const_byte;
    logic [7:0]                         s1_byte;
    logic                               word_done;

    // Hold the whole pipe while a finished word waits
    assign advance = !r_out_valid || i_ready;

    assign is_hdr   = r_bidx < tspk_pkg::BIDX_W'(tspk_pkg::HDR_LEN);
    assign pos      = tspk_pkg::ADDR_W'(r_bidx - tspk_pkg::BIDX_W'(tspk_pkg::HDR_LEN));
    assign from_mem = !is_hdr && (pos >= r_diff);

    always_comb begin
        const_byte = tspk_pkg::STUFF_BYTE;
        if (is_hdr) begin
            case (r_bidx[1:0])
                2'd0: const_byte = tspk_pkg::TS_SYNC_MARK;
                2'd1: const_byte = {1'b0, r_pusi, 1'b0, r_pid[12:8]};
                2'd2: const_byte = r_pid[7:0];
                2'd3: const_byte = {2'b00,
                                    (r_pad ? tspk_pkg::AFC_ADAPT_PAYLOAD
                                           : tspk_pkg::AFC_PAYLOAD_ONLY),
                                    r_cc};
                default: const_byte = tspk_pkg::TS_SYNC_MARK;
            endcase
        end else if (pos == '0) begin
            const_byte = 8'(r_diff - 1'b1);
        end else if (pos == tspk_pkg::ADDR_W'(1)) begin
            const_byte = 8'h00;
        end
    end

    assign o_rd_en   = advance && r_s0_active && from_mem;
    assign o_rd_addr = pos - r_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_active <= 1'b0;
            r_bidx      <= '0;
        end else if (i_launch.valid) begin
            r_s0_active <= 1'b1;
            r_bidx      <= '0;
        end else if (advance && r_s0_active) begin
            r_bidx <= r_bidx + 1'b1;
            if (r_bidx == tspk_pkg::BIDX_W'(tspk_pkg::PKT_LEN - 1)) begin
                r_s0_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_launch.valid) begin
            r_pusi <= i_launch.pusi;
            r_pad  <= i_launch.pad;
            r_diff <= i_launch.diff;
            r_cc   <= i_launch.cc;
            r_pid  <= i_launch.pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= r_s0_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_mem   <= from_mem;
            r_s1_const <= const_byte;
            r_s1_wend  <= (r_bidx[1:0] == 2'd3);
            r_s1_last  <= (r_bidx == tspk_pkg::BIDX_W'(tspk_pkg::PKT_LEN - 1));
        end
    end

    assign s1_byte   = r_s1_mem ? i_rd_data : r_s1_const;
    assign word_done = advance && r_s1_valid && r_s1_wend;

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid && !r_s1_wend) begin
            r_acc <= {r_acc[15:0], s1_byte};
        end
        if (word_done) begin
            r_out_word <= {r_acc, s1_byte};
            r_out_last <= r_s1_last;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (word_done) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_busy  = r_s0_active || r_s1_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;
    assign o_last  = r_out_last;

`ifndef NO_ASSERTIONS
    a_launch_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_launch.valid |-> !r_s0_active && !r_s1_valid)
        else $error("packet launched while emitter busy");

    a_bidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_active |-> r_bidx < tspk_pkg::BIDX_W'(tspk_pkg::PKT_LEN))
        else $error("byte index past packet end");

    a_last_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last |-> !r_s0_active)
        else $error("issue stage still active after final byte");

    a_last_on_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last |-> r_s1_wend)
        else $error("final byte not on a word boundary");
`endif

endmodule
